>>> design/csfw_pkg.sv
// shared types, constants and codes for the counting semaphore with fifo waiters
package csfw_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam int CMD_BITS    = 1;
    localparam int STATUS_BITS = 3;
    localparam int VAL_BITS    = 8;
    localparam int CFG_IDX_BITS = 8;

    localparam logic [CMD_BITS-1:0] CMD_WAIT    = 1'b0;
    localparam logic [CMD_BITS-1:0] CMD_RELEASE = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLDER_LIMIT = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_COUNT  = 8'd1;

    localparam logic [VAL_BITS-1:0] LIMIT_RESET = 8'd1;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_ACQUIRED = 3'd0,
        STAT_TIMEOUT  = 3'd1,
        STAT_QUEUED   = 3'd2,
        STAT_RELEASED = 3'd3,
        STAT_HANDED   = 3'd4,
        STAT_ERROR    = 3'd5
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic                we;
        logic [PTR_BITS-1:0] waddr;
        logic [ID_BITS-1:0]  wdata;
        logic                re;
        logic [PTR_BITS-1:0] raddr;
    } ram_req_t;

    function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] pos);
        logic [PTR_BITS-1:0] res;
        if (pos == PTR_BITS'(QUEUE_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = pos + PTR_BITS'(1);
        end
        return res;
    endfunction

endpackage

>>> design/csfw_ifs.sv
// request, response and configuration channel interfaces

interface csfw_req_if import csfw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_BITS-1:0] cmd;
    logic [VAL_BITS-1:0] requester_id;
    logic                block_if_full;

    modport source  (output valid, cmd, requester_id, block_if_full, input ready);
    modport sink    (input valid, cmd, requester_id, block_if_full, output ready);
    modport monitor (input valid, ready, cmd, requester_id, block_if_full);
endinterface

interface csfw_rsp_if import csfw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [VAL_BITS-1:0]    woken_id;
    logic [VAL_BITS-1:0]    holders_now;

    modport source  (output valid, status, woken_id, holders_now, input ready);
    modport sink    (input valid, status, woken_id, holders_now, output ready);
    modport monitor (input valid, ready, status, woken_id, holders_now);
endinterface

interface csfw_cfg_if import csfw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [VAL_BITS-1:0]     data;

    modport source  (output valid, index, data, input ready);
    modport sink    (input valid, index, data, output ready);
    modport monitor (input valid, ready, index, data);
endinterface

>>> design/csfw_ram.sv
// generic single write, single read ram with registered read data
module csfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ABITS-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [ABITS-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/csfw_ctrl.sv
// semaphore control: holder count, queue pointers, sequencer and result register
module csfw_ctrl import csfw_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    csfw_req_if.sink            req,
    csfw_rsp_if.source          rsp,
    csfw_cfg_if.sink            cfg,
    output ram_req_t            ram_req,
    input  logic [ID_BITS-1:0]  ram_rdata
);

    state_t              state_reg, state_next;
    logic [VAL_BITS-1:0] limit_reg, limit_next;
    logic [VAL_BITS-1:0] count_reg, count_next;
    logic [PTR_BITS-1:0] head_reg, head_next;
    logic [PTR_BITS-1:0] tail_reg, tail_next;
    logic [OCC_BITS-1:0] occ_reg, occ_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [VAL_BITS-1:0] woken_reg, woken_next;
    logic [VAL_BITS-1:0] holders_reg, holders_next;

    logic in_fire;
    logic load;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign in_fire   = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        status_next  = status_reg;
        woken_next   = '0;
        load         = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = tail_reg;
        ram_req.wdata = ID_BITS'(req.requester_id);
        ram_req.re    = 1'b0;
        ram_req.raddr = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req.cmd == CMD_WAIT)
                    begin
                        load = 1'b1;
                        if (count_reg < limit_reg)
                        begin
                            count_next  = count_reg + VAL_BITS'(1);
                            status_next = STAT_ACQUIRED;
                        end
                        else if (!req.block_if_full)
                        begin
                            status_next = STAT_TIMEOUT;
                        end
                        else if (occ_reg == OCC_BITS'(QUEUE_DEPTH))
                        begin
                            status_next = STAT_ERROR;
                        end
                        else
                        begin
                            ram_req.we  = 1'b1;
                            tail_next   = next_slot(tail_reg);
                            occ_next    = occ_reg + OCC_BITS'(1);
                            status_next = STAT_QUEUED;
                        end
                    end
                    else
                    begin
                        if (occ_reg != '0)
                        begin
                            ram_req.re = 1'b1;
                            head_next  = next_slot(head_reg);
                            occ_next   = occ_reg - OCC_BITS'(1);
                            state_next = ST_READ;
                        end
                        else if (count_reg == '0)
                        begin
                            load        = 1'b1;
                            status_next = STAT_ERROR;
                        end
                        else
                        begin
                            load        = 1'b1;
                            count_next  = count_reg - VAL_BITS'(1);
                            status_next = STAT_RELEASED;
                        end
                    end
                end
            end
            ST_READ:
            begin
                load        = 1'b1;
                status_next = STAT_HANDED;
                woken_next  = VAL_BITS'(ram_rdata);
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; this block does not enforce it
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_HOLDER_LIMIT:
                begin
                    limit_next = (cfg.data == '0) ? LIMIT_RESET : cfg.data;
                end
                CFG_START_COUNT:
                begin
                    count_next = (cfg.data > limit_reg) ? limit_reg : cfg.data;
                    head_next  = '0;
                    tail_next  = '0;
                    occ_next   = '0;
                end
                default:
                begin
                end
            endcase
        end

        holders_next = count_next;

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= status_next;
            woken_reg   <= woken_next;
            holders_reg <= holders_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.woken_id    = woken_reg;
    assign rsp.holders_now = holders_reg;

endmodule

>>> design/counting_semaphore_fifo_waiters.sv
// top level of the counting semaphore with a fifo of blocked requesters
//
//  channel  role    word
//  req      sink    cmd, requester_id, block_if_full
//  rsp      source  status, woken_id, holders_now
//  cfg      sink    index, data (always ready)
//
// a request loads the result register directly, while a release handed
// to a waiter reads the queue ram first; one request in flight at a time
// the result sits in an output register; the next request is taken while
// it drains, and a stalled result holds req off
// reset clears count and pointers and sets the limit to one; the queue ram
// needs no clearing
module counting_semaphore_fifo_waiters import csfw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    csfw_req_if.sink   req,
    csfw_rsp_if.source rsp,
    csfw_cfg_if.sink   cfg
);

    ram_req_t           ram_req;
    logic [ID_BITS-1:0] ram_rdata;

    csfw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    csfw_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> design/csfw_checker.sv
// port level checks for the semaphore, bound to the top level
module csfw_checker import csfw_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    csfw_req_if.sink    req,
    csfw_rsp_if.source  rsp
);

    // woken id is zero except on a hand-off
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STAT_HANDED) |-> rsp.woken_id == '0)
        else $error("woken_id nonzero without hand-off");

    // an acquire or hand-off leaves at least one holder
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STAT_ACQUIRED || rsp.status == STAT_HANDED))
        |-> rsp.holders_now != '0)
        else $error("holder count zero after grant");

    // a new result appears only after an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> ($past(req.valid && req.ready)
                              || $past(req.valid && req.ready, 2)))
        else $error("result without request");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.status)
                                       && $stable(rsp.woken_id)
                                       && $stable(rsp.holders_now)))
        else $error("stalled result changed");

endmodule

bind counting_semaphore_fifo_waiters csfw_checker u_csfw_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

>>> verif/counting_semaphore_fifo_waiters_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the counting semaphore with a fifo of blocked requesters
module counting_semaphore_fifo_waiters_test;
    import csfw_pkg::*;

    localparam int unsigned HALF_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES    = 4;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned RSP_HOLD_CYCLES = 300;
    localparam int unsigned END_SLACK       = 8;
    localparam int unsigned HOLD_PHASE      = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG = '1;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic [VAL_BITS-1:0] id;
        logic                may_block;
    } sem_req_t;

    typedef struct packed {
        status_t             status;
        logic [VAL_BITS-1:0] woken;
        logic [VAL_BITS-1:0] holders;
    } sem_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    csfw_req_if req_bus ();
    csfw_rsp_if rsp_bus ();
    csfw_cfg_if cfg_bus ();

    counting_semaphore_fifo_waiters dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // predicted semaphore state
    logic [VAL_BITS-1:0] sem_limit;
    logic [VAL_BITS-1:0] sem_count;
    logic [ID_BITS-1:0]  waiter_ids [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] waiter_head;
    logic [PTR_BITS-1:0] waiter_tail;
    int unsigned         waiter_occ;

    sem_req_t    pending_reqs [$];
    sem_rsp_t    expected_grants [$];
    sem_req_t    next_req;
    sem_req_t    incoming_req;
    sem_rsp_t    fresh_grant;
    sem_rsp_t    oldest_grant;
    logic        req_taken;
    logic        rsp_hold;
    logic        no_gaps = 1'b0;
    int unsigned req_gap_left = 0;
    int unsigned rsp_gap_left = 0;
    int unsigned phase_no = 0;
    int unsigned fail_count = 0;
    int unsigned results_checked = 0;
    int unsigned cycle_count = 0;
    int unsigned status_seen [2**STATUS_BITS];

    always #(HALF_PERIOD) clk = ~clk;

    function automatic sem_rsp_t predict_grant(input sem_req_t r);
        sem_rsp_t res;
        res.status = STAT_ERROR;
        res.woken  = '0;
        if (r.cmd == CMD_WAIT)
        begin
            if (sem_count < sem_limit)
            begin
                sem_count  = sem_count + 1'b1;
                res.status = STAT_ACQUIRED;
            end
            else if (!r.may_block)
            begin
                res.status = STAT_TIMEOUT;
            end
            else if (waiter_occ < QUEUE_DEPTH)
            begin
                waiter_ids[waiter_tail] = r.id[ID_BITS-1:0];
                waiter_tail = (waiter_tail == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : waiter_tail + 1'b1;
                waiter_occ  = waiter_occ + 1;
                res.status  = STAT_QUEUED;
            end
        end
        else if (waiter_occ != 0)
        begin
            res.woken   = VAL_BITS'(waiter_ids[waiter_head]);
            waiter_head = (waiter_head == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : waiter_head + 1'b1;
            waiter_occ  = waiter_occ - 1;
            res.status  = STAT_HANDED;
        end
        else if (sem_count != '0)
        begin
            sem_count  = sem_count - 1'b1;
            res.status = STAT_RELEASED;
        end
        res.holders = sem_count;
        return res;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [VAL_BITS-1:0] val);
        if (idx == CFG_HOLDER_LIMIT)
        begin
            sem_limit = (val == '0) ? VAL_BITS'(1) : val;
        end
        else if (idx == CFG_START_COUNT)
        begin
            sem_count   = (val > sem_limit) ? sem_limit : val;
            waiter_head = '0;
            waiter_tail = '0;
            waiter_occ  = 0;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [VAL_BITS-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic add_req(input logic [CMD_BITS-1:0] cmd, input logic [VAL_BITS-1:0] id,
                           input logic may_block);
        pending_reqs.push_back('{cmd: cmd, id: id, may_block: may_block});
    endtask

    task automatic add_random(input int unsigned n, input int unsigned wait_pct,
                              input int unsigned block_pct);
        sem_req_t r;
        repeat (n)
        begin
            r.cmd       = ($urandom_range(0, 99) < wait_pct) ? CMD_WAIT : CMD_RELEASE;
            r.id        = VAL_BITS'($urandom());
            r.may_block = ($urandom_range(0, 99) < block_pct);
            pending_reqs.push_back(r);
        end
    endtask

    task automatic drain_all();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || req_bus.valid || expected_grants.size() != 0);
    endtask

    task automatic next_phase();
        @(posedge clk);
        phase_no = phase_no + 1;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_bus.valid || req_taken)
            begin
                if (req_gap_left != 0)
                begin
                    req_bus.valid <= 1'b0;
                    req_gap_left  <= req_gap_left - 1;
                end
                else if (pending_reqs.size() != 0 && !no_gaps && $urandom_range(0, 7) == 0)
                begin
                    req_bus.valid <= 1'b0;
                    req_gap_left  <= $urandom_range(0, 17);
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    req_bus.valid         <= 1'b1;
                    req_bus.cmd           <= next_req.cmd;
                    req_bus.requester_id  <= next_req.id;
                    req_bus.block_if_full <= next_req.may_block;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // response ready driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_hold)
            begin
                rsp_bus.ready <= 1'b0;
            end
            else if (rsp_gap_left != 0)
            begin
                rsp_bus.ready <= 1'b0;
                rsp_gap_left  <= rsp_gap_left - 1;
            end
            else if (!no_gaps && $urandom_range(0, 7) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                rsp_gap_left  <= $urandom_range(0, 17);
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // long receiver stall so the block backs up into its request side
    initial
    begin
        rsp_hold = 1'b0;
        wait (phase_no == HOLD_PHASE);
        @(negedge clk);
        rsp_hold <= 1'b1;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
        rsp_hold <= 1'b0;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sem_limit   = LIMIT_RESET;
            sem_count   = '0;
            waiter_head = '0;
            waiter_tail = '0;
            waiter_occ  = 0;
            req_taken  <= 1'b0;
        end
        else
        begin
            req_taken <= req_bus.valid && req_bus.ready;
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                apply_reg(cfg_bus.index, cfg_bus.data);
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("result with no request waiting: status %0d", rsp_bus.status);
                    fail_count++;
                end
                else
                begin
                    oldest_grant = expected_grants.pop_front();
                    results_checked++;
                    if (rsp_bus.status !== oldest_grant.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest_grant.status, rsp_bus.status);
                        fail_count++;
                    end
                    if (rsp_bus.woken_id !== oldest_grant.woken)
                    begin
                        $error("woken_id: expected %0d, actual %0d",
                               oldest_grant.woken, rsp_bus.woken_id);
                        fail_count++;
                    end
                    if (rsp_bus.holders_now !== oldest_grant.holders)
                    begin
                        $error("holders_now: expected %0d, actual %0d",
                               oldest_grant.holders, rsp_bus.holders_now);
                        fail_count++;
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                incoming_req = '{cmd: req_bus.cmd, id: req_bus.requester_id,
                                 may_block: req_bus.block_if_full};
                fresh_grant = predict_grant(incoming_req);
                expected_grants.push_back(fresh_grant);
                status_seen[fresh_grant.status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        req_bus.valid         = 1'b0;
        req_bus.cmd           = CMD_WAIT;
        req_bus.requester_id  = '0;
        req_bus.block_if_full = 1'b0;
        rsp_bus.ready         = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = CFG_HOLDER_LIMIT;
        cfg_bus.data          = '0;
        rst_n                 = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: one holder, nothing held
        next_phase();
        add_req(CMD_RELEASE, 8'h00, 1'b0);
        add_req(CMD_WAIT, 8'h00, 1'b1);
        add_req(CMD_WAIT, 8'hFF, 1'b0);
        add_req(CMD_WAIT, 8'hFF, 1'b1);
        add_req(CMD_WAIT, 8'h5A, 1'b1);
        add_req(CMD_RELEASE, 8'hFF, 1'b1);
        add_req(CMD_RELEASE, 8'h00, 1'b0);
        add_req(CMD_RELEASE, 8'hA5, 1'b1);
        add_req(CMD_RELEASE, 8'h00, 1'b1);
        drain_all();

        // fill the waiter queue and overflow it
        next_phase();
        write_reg(CFG_HOLDER_LIMIT, 8'd1);
        write_reg(CFG_START_COUNT, 8'd1);
        @(posedge clk);
        for (int k = 0; k <= QUEUE_DEPTH; k++)
        begin
            add_req(CMD_WAIT, VAL_BITS'(k * 17), 1'b1);
        end
        drain_all();

        // zero limit, reload empties the full queue; receiver stalls here
        next_phase();
        write_reg(CFG_HOLDER_LIMIT, 8'd0);
        write_reg(CFG_START_COUNT, 8'd0);
        @(posedge clk);
        add_random(100, 50, 70);
        drain_all();

        next_phase();
        write_reg(CFG_HOLDER_LIMIT, 8'd255);
        write_reg(CFG_START_COUNT, 8'd255);
        write_reg(CFG_NO_REG, 8'd0);
        @(posedge clk);
        add_random(80, 50, 60);
        drain_all();

        // start count above the limit gets clamped
        next_phase();
        write_reg(CFG_HOLDER_LIMIT, 8'd4);
        write_reg(CFG_START_COUNT, 8'd200);
        @(posedge clk);
        add_random(120, 70, 90);
        drain_all();

        // limit lowered below the current count
        next_phase();
        write_reg(CFG_HOLDER_LIMIT, 8'd8);
        write_reg(CFG_START_COUNT, 8'd8);
        write_reg(CFG_HOLDER_LIMIT, 8'd3);
        @(posedge clk);
        add_random(100, 40, 60);
        drain_all();

        next_phase();
        write_reg(CFG_HOLDER_LIMIT, 8'd2);
        write_reg(CFG_START_COUNT, 8'd0);
        @(posedge clk);
        add_random(100, 30, 50);
        drain_all();

        next_phase();
        write_reg(CFG_HOLDER_LIMIT, 8'd128);
        write_reg(CFG_START_COUNT, 8'd100);
        @(posedge clk);
        add_random(100, 55, 70);
        drain_all();

        // back to back with no idling
        next_phase();
        no_gaps = 1'b1;
        write_reg(CFG_HOLDER_LIMIT, 8'd1);
        write_reg(CFG_START_COUNT, 8'd1);
        @(posedge clk);
        add_random(150, 60, 80);
        drain_all();

        repeat (END_SLACK) @(posedge clk);
        if (expected_grants.size() != 0)
        begin
            $error("%0d results never arrived", expected_grants.size());
            fail_count++;
        end
        $display("checked %0d results across %0d register settings, %0d mismatches",
                 results_checked, phase_no, fail_count);
        $display("acquired %0d, timeout %0d, queued %0d, released %0d, handed %0d, error %0d",
                 status_seen[STAT_ACQUIRED], status_seen[STAT_TIMEOUT],
                 status_seen[STAT_QUEUED], status_seen[STAT_RELEASED],
                 status_seen[STAT_HANDED], status_seen[STAT_ERROR]);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/csfw_pkg.sv
design/csfw_ifs.sv
design/csfw_ram.sv
design/csfw_ctrl.sv
design/counting_semaphore_fifo_waiters.sv
design/csfw_checker.sv
verif/counting_semaphore_fifo_waiters_test.sv
